// File: rtl/bloom_filter_double_hash_assert.svh
// Assertion macros used by the bloom filter top-level RTL.
`ifndef BLOOM_FILTER_DOUBLE_HASH_ASSERT_SVH
`define BLOOM_FILTER_DOUBLE_HASH_ASSERT_SVH

// Implication checked on every rising clock edge outside reset.
`define BF_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication checked outside reset.
`define BF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/bfdh_pkg.sv
// Package with types and constants for the double-hash bloom filter.
package bfdh_pkg;

   localparam int unsigned MaxBits    = 65536;
   localparam int unsigned MaxHashes  = 16;
   localparam logic [63:0] Djb2Init   = 64'd5381;
   localparam int unsigned NumBitsW   = 17;
   localparam int unsigned NumHashesW = 5;
   localparam int unsigned CsrDataW   = 17;

   // Register indexes of the configuration port.
   localparam logic CsrNumBits   = 1'b0;
   localparam logic CsrNumHashes = 1'b1;

   // Request kinds.
   localparam logic ReqInsert = 1'b0;
   localparam logic ReqQuery  = 1'b1;

   // Top-level sequencer states.
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MOD,
      ST_READ,
      ST_CHECK,
      ST_DONE
   } state_type;

   // Handshake between the sequencer and the modulo unit.
   typedef struct packed {
      logic start;
      logic busy;
      logic done;
   } mod_ctrl_type;

endpackage

// File: rtl/bloom_filter_double_hash.sv
// Bloom filter with djb2/sdbm double hashing over a one-bit-wide memory.
// A key arrives one byte per start pulse; a non-final byte keeps the block idle and
// causes no result. A final byte derives num_hashes positions. Each position passes
// through the bit-serial modulo unit (start, 64 remainder steps and done), a memory
// read and a check or write-back. After the final byte is accepted, busy stays high
// until the last position is done, and rsp_valid pulses in the first cycle with
// busy low again. The receiver cannot stall: every result is on the rsp_ ports for
// exactly one cycle. After reset a clearing pass writes zero to every memory entry
// while busy is high; configuration writes are taken at any time.
module bloom_filter_double_hash #(
   parameter int unsigned MAX_BITS   = bfdh_pkg::MaxBits,
   parameter int unsigned MAX_HASHES = bfdh_pkg::MaxHashes
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_type,
   input  logic [7:0]                    req_byte_value,
   input  logic                          req_last_byte,
   output logic                          rsp_valid,
   output logic                          rsp_was_query,
   output logic                          rsp_maybe_present,
   input  logic                          csr_write_enable,
   input  logic                          csr_index,
   input  logic [bfdh_pkg::CsrDataW-1:0] csr_write_data
);

   localparam int unsigned AddrW = $clog2(MAX_BITS);
   localparam int unsigned ModW  = $clog2(MAX_BITS + 1);
   localparam int unsigned KW    = $clog2(MAX_HASHES + 1);

   bfdh_pkg::state_type state_ff, state_in;

   logic [bfdh_pkg::NumBitsW-1:0]   num_bits_ff;
   logic [bfdh_pkg::NumHashesW-1:0] num_hashes_ff;
   logic [63:0] hash_one_ff, hash_one_in, hash_two_ff, hash_two_in;
   logic [63:0] pos_ff, pos_in;
   logic [KW-1:0] left_ff, left_in;
   logic [KW-1:0] eff_k;
   logic [ModW-1:0] eff_nb;
   logic query_ff, query_in, all_ff, all_in;
   logic [AddrW-1:0] clear_ff, clear_in;
   logic [AddrW-1:0] addr_ff, addr_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_query_ff, rsp_query_in, rsp_maybe_ff, rsp_maybe_in;
   logic mod_start;
   bfdh_pkg::mod_ctrl_type mod_ctrl;
   logic [ModW-1:0] mod_rem;
   logic [63:0] h1_next, h2_next;
   logic        mem [MAX_BITS];
   logic        mem_rd_ff;
   logic        mem_we;
   logic [AddrW-1:0] mem_waddr;
   logic        mem_wdata;
   logic        accept;

   // Effective register values with zero and saturation handling.
   always_comb begin
      if (num_bits_ff == '0) begin
         eff_nb = ModW'(1);
      end else if (32'(num_bits_ff) > MAX_BITS) begin
         eff_nb = ModW'(MAX_BITS);
      end else begin
         eff_nb = ModW'(num_bits_ff);
      end
      if (num_hashes_ff == '0) begin
         eff_k = KW'(1);
      end else if (32'(num_hashes_ff) > MAX_HASHES) begin
         eff_k = KW'(MAX_HASHES);
      end else begin
         eff_k = KW'(num_hashes_ff);
      end
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         num_bits_ff   <= bfdh_pkg::NumBitsW'(65536);
         num_hashes_ff <= bfdh_pkg::NumHashesW'(7);
      end else if (csr_write_enable) begin
         if (csr_index == bfdh_pkg::CsrNumBits) begin
            num_bits_ff <= csr_write_data;
         end else begin
            num_hashes_ff <= csr_write_data[bfdh_pkg::NumHashesW-1:0];
         end
      end
   end

   // Running hash updates for one byte.
   assign h1_next = (hash_one_ff << 5) + hash_one_ff + {56'd0, req_byte_value};
   assign h2_next = {56'd0, req_byte_value} + (hash_two_ff << 6) + (hash_two_ff << 16)
                    - hash_two_ff;
   assign accept  = start && !busy;

   bfdh_mod #(.ModW(ModW)) u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (pos_ff),
      .modulus   (eff_nb),
      .ctrl      (mod_ctrl),
      .remainder (mod_rem)
   );

   // Sequencer: clear pass, byte hashing, per-position modulo, read and check or set.
   always_comb begin
      state_in     = state_ff;
      hash_one_in  = hash_one_ff;
      hash_two_in  = hash_two_ff;
      pos_in       = pos_ff;
      left_in      = left_ff;
      query_in     = query_ff;
      all_in       = all_ff;
      clear_in     = clear_ff;
      addr_in      = addr_ff;
      rsp_valid_in = 1'b0;
      rsp_query_in = rsp_query_ff;
      rsp_maybe_in = rsp_maybe_ff;
      mod_start    = 1'b0;
      mem_we       = 1'b0;
      mem_waddr    = addr_ff;
      mem_wdata    = 1'b1;
      busy         = 1'b1;
      case (state_ff)
         bfdh_pkg::ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clear_ff;
            mem_wdata = 1'b0;
            clear_in  = clear_ff + AddrW'(1);
            if (32'(clear_ff) == MAX_BITS - 1) begin
               state_in = bfdh_pkg::ST_IDLE;
            end
         end
         bfdh_pkg::ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               if (req_last_byte) begin
                  hash_one_in = h1_next;
                  hash_two_in = h2_next;
                  pos_in      = h1_next;
                  left_in     = eff_k;
                  query_in    = req_type;
                  all_in      = 1'b1;
                  state_in    = bfdh_pkg::ST_MOD;
               end else begin
                  hash_one_in = h1_next;
                  hash_two_in = h2_next;
               end
            end
         end
         bfdh_pkg::ST_MOD: begin
            if (!mod_ctrl.busy && !mod_ctrl.done) begin
               mod_start = 1'b1;
            end else if (mod_ctrl.done) begin
               addr_in  = AddrW'(mod_rem);
               state_in = bfdh_pkg::ST_READ;
            end
         end
         bfdh_pkg::ST_READ: begin
            state_in = bfdh_pkg::ST_CHECK;
         end
         bfdh_pkg::ST_CHECK: begin
            if (query_ff == bfdh_pkg::ReqQuery) begin
               if (!mem_rd_ff) begin
                  all_in = 1'b0;
               end
            end else begin
               mem_we = 1'b1;
            end
            pos_in  = pos_ff + hash_two_ff;
            left_in = left_ff - KW'(1);
            if (left_ff == KW'(1)) begin
               state_in = bfdh_pkg::ST_DONE;
            end else begin
               state_in = bfdh_pkg::ST_MOD;
            end
         end
         bfdh_pkg::ST_DONE: begin
            rsp_valid_in = 1'b1;
            rsp_query_in = query_ff;
            rsp_maybe_in = (query_ff == bfdh_pkg::ReqQuery) && all_ff;
            hash_one_in  = bfdh_pkg::Djb2Init;
            hash_two_in  = '0;
            state_in     = bfdh_pkg::ST_IDLE;
         end
         default: begin
            state_in = bfdh_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bfdh_pkg::ST_CLEAR;
         clear_ff     <= '0;
         hash_one_ff  <= bfdh_pkg::Djb2Init;
         hash_two_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         left_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         clear_ff     <= clear_in;
         hash_one_ff  <= hash_one_in;
         hash_two_ff  <= hash_two_in;
         rsp_valid_ff <= rsp_valid_in;
         left_ff      <= left_in;
      end
      pos_ff       <= pos_in;
      query_ff     <= query_in;
      all_ff       <= all_in;
      addr_ff      <= addr_in;
      rsp_query_ff <= rsp_query_in;
      rsp_maybe_ff <= rsp_maybe_in;
   end

   // Bit memory with registered read.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      mem_rd_ff <= mem[addr_ff];
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_was_query     = rsp_query_ff;
   assign rsp_maybe_present = rsp_maybe_ff;

`include "bloom_filter_double_hash_assert.svh"

   // An accepted item only happens in the idle state.
   `BF_ASSERT_IMPL(a_accept_idle, clock, reset, accept, state_ff == bfdh_pkg::ST_IDLE, "not idle")
   // A result always follows the final step of a key.
   `BF_ASSERT_NEXT(a_done_rsp, clock, reset, state_ff == bfdh_pkg::ST_DONE, rsp_valid, "no result")
   // An insert never reports presence.
   `BF_ASSERT_IMPL(a_ins_zero, clock, reset, rsp_valid && !rsp_was_query, !rsp_maybe_present, "ack set")

endmodule

// File: rtl/bfdh_mod.sv
// Restoring divider that returns a 64-bit value modulo a narrow modulus, one bit per cycle.
module bfdh_mod #(
   parameter int unsigned ModW = 17
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [63:0]        dividend,
   input  logic [ModW-1:0]    modulus,
   output bfdh_pkg::mod_ctrl_type ctrl,
   output logic [ModW-1:0]    remainder
);

   logic [63:0]     shift_ff, shift_in;
   logic [ModW:0]   rem_ff, rem_in;
   logic [6:0]      count_ff, count_in;
   logic            busy_ff, busy_in;
   logic            done_ff, done_in;
   logic [ModW:0]   trial;

   // One remainder bit per cycle, most significant dividend bit first.
   always_comb begin
      shift_in = shift_ff;
      rem_in   = rem_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      trial    = {rem_ff[ModW-1:0], shift_ff[63]};
      if (start) begin
         shift_in = dividend;
         rem_in   = '0;
         count_in = 7'd64;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         shift_in = {shift_ff[62:0], 1'b0};
         if (trial >= {1'b0, modulus}) begin
            rem_in = trial - {1'b0, modulus};
         end else begin
            rem_in = trial;
         end
         count_in = count_ff - 7'd1;
         if (count_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
   end

   assign ctrl.start = start;
   assign ctrl.busy  = busy_ff;
   assign ctrl.done  = done_ff;
   assign remainder  = rem_ff[ModW-1:0];

endmodule

// File: verif/bloom_filter_double_hash_tb.sv
// Self-checking testbench for the double-hash bloom filter.
`timescale 1ns / 1ps

module bloom_filter_double_hash_tb;

   localparam int WatchdogLimit = 200000;

   typedef struct {
      logic was_query;
      logic maybe_present;
   } answer_type;

   logic                          clock = 1'b0;
   logic                          reset;
   logic                          start;
   logic                          busy;
   logic                          req_type;
   logic [7:0]                    req_byte_value;
   logic                          req_last_byte;
   logic                          rsp_valid;
   logic                          rsp_was_query;
   logic                          rsp_maybe_present;
   logic                          csr_write_enable;
   logic                          csr_index;
   logic [bfdh_pkg::CsrDataW-1:0] csr_write_data;

   // Predictor state: configuration, running hashes and the filter bits.
   logic [bfdh_pkg::NumBitsW-1:0]   cfg_num_bits;
   logic [bfdh_pkg::NumHashesW-1:0] cfg_num_hashes;
   logic [63:0]                     run_hash_a;
   logic [63:0]                     run_hash_b;
   bit                              filter_bits [bfdh_pkg::MaxBits];
   answer_type                      pending_answers [$];

   // Keys sent so far, kept so that they can be queried again.
   logic [47:0] known_keys [$];
   int          known_lens [$];

   bit failed = 1'b0;
   int stall_cycles = 0;

   bloom_filter_double_hash dut (.*);

   always #5 clock = ~clock;

   // Update the predictor for one accepted byte; the final byte of a key gives an answer.
   function automatic void predict_item(logic kind, logic [7:0] value, logic last);
      logic [63:0] modulus;
      logic [63:0] pos;
      int          count;
      logic        all_set;
      answer_type  ans;
      run_hash_a = (run_hash_a << 5) + run_hash_a + 64'(value);
      run_hash_b = 64'(value) + (run_hash_b << 6) + (run_hash_b << 16) - run_hash_b;
      if (!last) return;
      modulus = (cfg_num_bits == 0) ? 64'd1 :
                (cfg_num_bits > bfdh_pkg::MaxBits) ? 64'(bfdh_pkg::MaxBits) :
                64'(cfg_num_bits);
      count = (cfg_num_hashes == 0) ? 1 :
              (cfg_num_hashes > bfdh_pkg::MaxHashes) ? bfdh_pkg::MaxHashes :
              int'(cfg_num_hashes);
      all_set = 1'b1;
      for (int i = 0; i < count; i++) begin
         pos = (run_hash_a + 64'(i) * run_hash_b) % modulus;
         if (kind == bfdh_pkg::ReqQuery) begin
            if (!filter_bits[pos]) all_set = 1'b0;
         end else begin
            filter_bits[pos] = 1'b1;
         end
      end
      run_hash_a = bfdh_pkg::Djb2Init;
      run_hash_b = '0;
      ans.was_query = kind;
      ans.maybe_present = (kind == bfdh_pkg::ReqQuery) ? all_set : 1'b0;
      pending_answers.push_back(ans);
   endfunction

   // Send one item after a random gap and wait until it is taken.
   task automatic send_byte(logic kind, logic [7:0] value, logic last);
      int gap;
      gap = $urandom_range(0, 4);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_type <= kind;
      req_byte_value <= value;
      req_last_byte <= last;
      do @(posedge clock); while (busy !== 1'b0);
      predict_item(kind, value, last);
   endtask

   // Send a whole key; bytes before the last carry a random request kind.
   task automatic send_key(logic kind, logic [47:0] key, int len);
      for (int i = 0; i < len; i++)
         send_byte((i == len - 1) ? kind : logic'($urandom_range(0, 1)),
                   key[8*i +: 8], i == len - 1);
   endtask

   // Drop start, let all answers drain and the block settle before a register write.
   task automatic wait_idle();
      start <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(logic index, logic [bfdh_pkg::CsrDataW-1:0] data);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= index;
      csr_write_data <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (index == bfdh_pkg::CsrNumBits) cfg_num_bits = data;
      else cfg_num_hashes = data[bfdh_pkg::NumHashesW-1:0];
   endtask

   task automatic set_config(logic [bfdh_pkg::CsrDataW-1:0] bits, logic [4:0] hashes);
      wait_idle();
      write_reg(bfdh_pkg::CsrNumBits, bits);
      // Upper data bits are random; only the low five count for the hash count.
      write_reg(bfdh_pkg::CsrNumHashes, {12'($urandom), hashes});
   endtask

   task automatic send_new_key(logic kind);
      logic [47:0] key;
      int          len;
      key = {$urandom, $urandom};
      len = $urandom_range(1, 6);
      known_keys.push_back(key);
      known_lens.push_back(len);
      send_key(kind, key, len);
   endtask

   // Extremes of the byte field, zero bytes, and queries of inserted keys.
   task automatic test_directed();
      send_key(bfdh_pkg::ReqInsert, 48'h0, 1);
      send_key(bfdh_pkg::ReqQuery, 48'h0, 1);
      send_key(bfdh_pkg::ReqInsert, 48'hFF_01_80_00_FF, 5);
      send_key(bfdh_pkg::ReqQuery, 48'hFF_01_80_00_FF, 5);
      send_key(bfdh_pkg::ReqQuery, 48'h7F_FE, 2);
      send_key(bfdh_pkg::ReqQuery, 48'hFF, 1);
      send_key(bfdh_pkg::ReqInsert, 48'h55_AA_FF_FF_FF_FF, 6);
      send_key(bfdh_pkg::ReqQuery, 48'h55_AA_FF_FF_FF_FF, 6);
   endtask

   // Register extremes, including zero and values above the maxima.
   task automatic test_register_extremes();
      set_config(17'd0, 5'd0);
      test_directed();
      set_config(17'd131071, 5'd31);
      test_directed();
      set_config(17'd1, 5'd16);
      send_key(bfdh_pkg::ReqQuery, 48'h42, 1);
      send_key(bfdh_pkg::ReqInsert, 48'h42, 1);
      send_key(bfdh_pkg::ReqQuery, 48'h99, 1);
   endtask

   // Random keys under one setting; about half are known keys sent again, mostly as queries.
   task automatic test_random_keys(logic [bfdh_pkg::CsrDataW-1:0] bits, logic [4:0] hashes,
                                   int items);
      int start_count;
      int pick;
      set_config(bits, hashes);
      start_count = 0;
      while (start_count < items) begin
         if (known_keys.size() != 0 && $urandom_range(0, 9) < 5) begin
            pick = $urandom_range(0, known_keys.size() - 1);
            send_key(logic'($urandom_range(0, 3) != 0), known_keys[pick], known_lens[pick]);
            start_count += known_lens[pick];
         end else begin
            send_new_key(logic'($urandom_range(0, 1)));
            start_count += known_lens[known_lens.size() - 1];
         end
      end
   endtask

   // Compare each answer with the oldest expectation.
   always @(posedge clock) begin
      answer_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (pending_answers.size() == 0) begin
            $error("answer with no item waiting");
            failed = 1'b1;
         end else begin
            want = pending_answers.pop_front();
            if (rsp_was_query !== want.was_query) begin
               $error("was_query: expected %0b, actual %0b", want.was_query, rsp_was_query);
               failed = 1'b1;
            end
            if (rsp_maybe_present !== want.maybe_present) begin
               $error("maybe_present: expected %0b, actual %0b",
                      want.maybe_present, rsp_maybe_present);
               failed = 1'b1;
            end
         end
      end
   end

   // Watchdog on cycles without any accepted item or answer.
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WatchdogLimit) begin
         $display("bloom_filter_double_hash verification failed");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_type = 1'b0;
      req_byte_value = '0;
      req_last_byte = 1'b0;
      csr_write_enable = 1'b0;
      csr_index = 1'b0;
      csr_write_data = '0;
      cfg_num_bits = bfdh_pkg::NumBitsW'(bfdh_pkg::MaxBits);
      cfg_num_hashes = 5'd7;
      run_hash_a = bfdh_pkg::Djb2Init;
      run_hash_b = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_register_extremes();
      test_random_keys(17'd65536, 5'd7, 250);
      test_random_keys(17'd8, 5'd16, 250);
      test_random_keys(17'd97, 5'd3, 250);
      test_random_keys(17'($urandom_range(1, 2000)), 5'($urandom_range(1, 16)), 250);
      test_random_keys(17'd1, 5'd1, 250);
      test_random_keys(17'($urandom_range(2000, 65536)), 5'($urandom_range(1, 8)), 250);

      wait_idle();
      repeat (20) @(posedge clock);
      if (!failed && pending_answers.size() == 0) begin
         $display("bloom_filter_double_hash verification clean");
      end else begin
         $display("bloom_filter_double_hash verification failed");
      end
      $finish;
   end

endmodule

// File: files.f
+incdir+rtl
rtl/bfdh_pkg.sv
rtl/bfdh_mod.sv
rtl/bloom_filter_double_hash.sv
verif/bloom_filter_double_hash_tb.sv
